// ----- rtl/mwps_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the mecanum wheel PI speed loop.
// No dependencies; the datapath, sequencer and top level import this package.

package mwps_pkg;

   localparam int NUM_WHEELS = 4;
   localparam int WHEEL_W    = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int DUTY_W      = 13;

   // Clamp limits: drive in counts, integral part in Q.8
   localparam int DRIVE_LIMIT = 8000;
   localparam int IPART_LIMIT = 8000 * 256;

   // Register indexes: proportional gains first, then integral gains
   localparam logic [CSR_INDEX_W-1:0] CSR_P_GAIN0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_I_GAIN0 = 3'd4;

   // Mixing matrix signs, bit k for wheel k: x+y-z, -x+y+z, x+y+z, -x+y-z
   localparam logic [NUM_WHEELS-1:0] MIX_NEG_X = 4'b1010;
   localparam logic [NUM_WHEELS-1:0] MIX_NEG_Z = 4'b1001;
   // Encoders of wheels 0 and 3 count the other way
   localparam logic [NUM_WHEELS-1:0] ENC_NEG   = 4'b1001;

   // Datapath operations issued by the sequencer
   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_MIX   = 3'd1,
      OP_ERR   = 3'd2,
      OP_IMUL  = 3'd3,
      OP_PMUL  = 3'd4,
      OP_DRIVE = 3'd5,
      OP_LOAD  = 3'd6
   } op_type;

   typedef struct packed {
      logic                load_req;
      op_type              op;
      logic [WHEEL_W-1:0]  wheel;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

   typedef struct packed {
      logic signed [15:0] cmd_x;
      logic signed [15:0] cmd_y;
      logic signed [15:0] cmd_rot;
      logic        [15:0] speed_scale;
      logic signed [15:0] enc_count0;
      logic signed [15:0] enc_count1;
      logic signed [15:0] enc_count2;
      logic signed [15:0] enc_count3;
   } req_item_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty0;
      logic              forward0;
      logic [DUTY_W-1:0] duty1;
      logic              forward1;
      logic [DUTY_W-1:0] duty2;
      logic              forward2;
      logic [DUTY_W-1:0] duty3;
      logic              forward3;
   } rsp_item_type;

endpackage

// ----- rtl/mwps_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the command item and the drive item.
// No dependencies.

interface mwps_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] cmd_x;
   logic signed [15:0] cmd_y;
   logic signed [15:0] cmd_rot;
   logic        [15:0] speed_scale;
   logic signed [15:0] enc_count0;
   logic signed [15:0] enc_count1;
   logic signed [15:0] enc_count2;
   logic signed [15:0] enc_count3;

   modport source (
      output valid, cmd_x, cmd_y, cmd_rot, speed_scale,
             enc_count0, enc_count1, enc_count2, enc_count3,
      input  ready
   );
   modport sink (
      input  valid, cmd_x, cmd_y, cmd_rot, speed_scale,
             enc_count0, enc_count1, enc_count2, enc_count3,
      output ready
   );
endinterface

interface mwps_rsp_if;
   logic        valid;
   logic        ready;
   logic [12:0] duty0;
   logic        forward0;
   logic [12:0] duty1;
   logic        forward1;
   logic [12:0] duty2;
   logic        forward2;
   logic [12:0] duty3;
   logic        forward3;

   modport source (
      output valid, duty0, forward0, duty1, forward1,
             duty2, forward2, duty3, forward3,
      input  ready
   );
   modport sink (
      input  valid, duty0, forward0, duty1, forward1,
             duty2, forward2, duty3, forward3,
      output ready
   );
endinterface

// ----- rtl/mwps_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: gain registers, error sums, one shared multiplier and the
// output register. Depends on mwps_pkg; driven by mwps_ctrl commands.

module mwps_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [mwps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mwps_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  mwps_pkg::cmd_type                    cmd,
   output mwps_pkg::stat_type                   stat,
   input  mwps_pkg::req_item_type               req_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output mwps_pkg::rsp_item_type               rsp_item
);
   import mwps_pkg::*;

   localparam logic signed [34:0] IPART_MAX = 35'(IPART_LIMIT);
   localparam logic signed [34:0] IPART_MIN = -35'(IPART_LIMIT);
   localparam logic signed [26:0] DRIVE_MAX = 27'(DRIVE_LIMIT);
   localparam logic signed [26:0] DRIVE_MIN = -27'(DRIVE_LIMIT);
   localparam logic signed [26:0] TGT_MAX   = 27'sd32767;
   localparam logic signed [26:0] TGT_MIN   = -27'sd32768;

   // Divide by 256, rounding toward zero
   function automatic logic signed [26:0] trunc8(input logic signed [34:0] v);
      logic signed [26:0] q;
      q = v[34:8];
      if (v[34] && (v[7:0] != 8'd0)) begin
         q = q + 27'sd1;
      end
      return q;
   endfunction

   // Configuration and loop state
   logic [15:0]        p_gain_ff    [NUM_WHEELS];
   logic [15:0]        i_gain_ff    [NUM_WHEELS];
   logic signed [15:0] err_sum_ff   [NUM_WHEELS];

   req_item_type       req_ff;
   logic signed [34:0] prod_ff, prod_in;
   logic signed [15:0] err_ff, err_in;
   logic signed [22:0] ipart_ff;
   logic [DUTY_W-1:0]  duty_ff      [NUM_WHEELS];
   logic               fwd_ff       [NUM_WHEELS];
   logic               rsp_valid_ff;
   rsp_item_type       rsp_item_ff;

   logic signed [17:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [17:0] mix_x, mix_y, mix_z, mix;
   logic signed [15:0] enc_raw;
   logic signed [26:0] tgt_q;
   logic signed [15:0] target;
   logic signed [34:0] total;
   logic signed [26:0] drv_q;
   logic signed [13:0] drive;
   logic               fwd;
   logic [DUTY_W-1:0]  duty;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_WHEELS; k++) begin
            p_gain_ff[k] <= '0;
            i_gain_ff[k] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index < CSR_I_GAIN0) begin
            p_gain_ff[csr_index[WHEEL_W-1:0]] <= csr_wdata;
         end else begin
            i_gain_ff[csr_index[WHEEL_W-1:0]] <= csr_wdata;
         end
      end
   end

   // Input item capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_item;
      end
   end

   // Wheel mixing for the selected wheel
   always_comb begin
      mix_x = 18'(req_ff.cmd_x);
      mix_y = 18'(req_ff.cmd_y);
      mix_z = 18'(req_ff.cmd_rot);
      if (MIX_NEG_X[cmd.wheel]) begin
         mix_x = -mix_x;
      end
      if (MIX_NEG_Z[cmd.wheel]) begin
         mix_z = -mix_z;
      end
      mix = mix_x + mix_y + mix_z;
   end

   // Shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MIX: begin
            mul_a = mix;
            mul_b = {1'b0, req_ff.speed_scale};
         end
         OP_IMUL: begin
            mul_a = 18'(err_sum_ff[cmd.wheel]);
            mul_b = {1'b0, i_gain_ff[cmd.wheel]};
         end
         OP_PMUL: begin
            mul_a = 18'(err_ff);
            mul_b = {1'b0, p_gain_ff[cmd.wheel]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Target saturation and speed error
   always_comb begin
      case (cmd.wheel)
         2'd0:    enc_raw = req_ff.enc_count0;
         2'd1:    enc_raw = req_ff.enc_count1;
         2'd2:    enc_raw = req_ff.enc_count2;
         default: enc_raw = req_ff.enc_count3;
      endcase
      tgt_q = trunc8(prod_ff);
      if (tgt_q > TGT_MAX) begin
         target = 16'sd32767;
      end else if (tgt_q < TGT_MIN) begin
         target = -16'sd32768;
      end else begin
         target = tgt_q[15:0];
      end
      // a negated encoder turns the subtraction into an addition
      if (ENC_NEG[cmd.wheel]) begin
         err_in = target + enc_raw;
      end else begin
         err_in = target - enc_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_ERR) begin
         err_ff <= err_in;
      end
   end

   // Wrapping error accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_WHEELS; k++) begin
            err_sum_ff[k] <= '0;
         end
      end else if (cmd.op == OP_ERR) begin
         err_sum_ff[cmd.wheel] <= err_sum_ff[cmd.wheel] + err_in;
      end
   end

   // Integral part clamp, taken while the P product is formed
   always_ff @(posedge clock) begin
      if (cmd.op == OP_PMUL) begin
         if (prod_ff > IPART_MAX) begin
            ipart_ff <= 23'(IPART_LIMIT);
         end else if (prod_ff < IPART_MIN) begin
            ipart_ff <= -23'(IPART_LIMIT);
         end else begin
            ipart_ff <= prod_ff[22:0];
         end
      end
   end

   // Drive: sum, scale down, clamp, sign-magnitude
   always_comb begin
      total = prod_ff + 35'(ipart_ff);
      drv_q = trunc8(total);
      if (drv_q > DRIVE_MAX) begin
         drive = 14'(DRIVE_LIMIT);
      end else if (drv_q < DRIVE_MIN) begin
         drive = -14'(DRIVE_LIMIT);
      end else begin
         drive = drv_q[13:0];
      end
      fwd = (drive > 14'sd0);
      if (fwd) begin
         duty = drive[DUTY_W-1:0];
      end else begin
         duty = 13'(-drive);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_DRIVE) begin
         duty_ff[cmd.wheel] <= duty;
         fwd_ff[cmd.wheel]  <= fwd;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_LOAD) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         rsp_item_ff.duty0    <= duty_ff[0];
         rsp_item_ff.forward0 <= fwd_ff[0];
         rsp_item_ff.duty1    <= duty_ff[1];
         rsp_item_ff.forward1 <= fwd_ff[1];
         rsp_item_ff.duty2    <= duty_ff[2];
         rsp_item_ff.forward2 <= fwd_ff[2];
         rsp_item_ff.duty3    <= duty_ff[3];
         rsp_item_ff.forward3 <= fwd_ff[3];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_item      = rsp_item_ff;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

endmodule

// ----- rtl/mwps_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer: walks the four wheels through mix, error, I, P and drive
// steps on the shared datapath. Depends on mwps_pkg.

module mwps_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output mwps_pkg::cmd_type     cmd,
   input  mwps_pkg::stat_type    stat
);
   import mwps_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MIX   = 7'b0000010,
      ST_ERR   = 7'b0000100,
      ST_IMUL  = 7'b0001000,
      ST_PMUL  = 7'b0010000,
      ST_DRIVE = 7'b0100000,
      ST_LOAD  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [WHEEL_W-1:0] wheel_ff, wheel_in;

   // Next state and command decode
   always_comb begin
      state_in     = state_ff;
      wheel_in     = wheel_ff;
      req_ready    = 1'b0;
      cmd.load_req = 1'b0;
      cmd.op       = OP_NONE;
      cmd.wheel    = wheel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               wheel_in     = '0;
               state_in     = ST_MIX;
            end
         end
         ST_MIX: begin
            cmd.op   = OP_MIX;
            state_in = ST_ERR;
         end
         ST_ERR: begin
            cmd.op   = OP_ERR;
            state_in = ST_IMUL;
         end
         ST_IMUL: begin
            cmd.op   = OP_IMUL;
            state_in = ST_PMUL;
         end
         ST_PMUL: begin
            cmd.op   = OP_PMUL;
            state_in = ST_DRIVE;
         end
         ST_DRIVE: begin
            cmd.op = OP_DRIVE;
            if (wheel_ff == WHEEL_W'(NUM_WHEELS - 1)) begin
               state_in = ST_LOAD;
            end else begin
               wheel_in = wheel_ff + 1'b1;
               state_in = ST_MIX;
            end
         end
         ST_LOAD: begin
            // wait until the output register can take the new item
            if (stat.out_free) begin
               cmd.op   = OP_LOAD;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wheel_ff <= '0;
      end else begin
         state_ff <= state_in;
         wheel_ff <= wheel_in;
      end
   end

   // An item is only taken while no other is in flight
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |-> (state_ff == ST_IDLE))
      else $error("item loaded while busy");

   // The output register is never overwritten while still held
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LOAD) |-> stat.out_free)
      else $error("result loaded over a pending one");

   // A result is published only after the last wheel's drive step
   a_load_after_drive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) && !$past(state_ff == ST_LOAD)
         |-> $past(cmd.op == OP_DRIVE) && ($past(wheel_ff) == WHEEL_W'(NUM_WHEELS - 1)))
      else $error("load entered without finishing all wheels");

   // After a load the sequencer is back to idle
   a_idle_after_load: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LOAD) |=> (state_ff == ST_IDLE))
      else $error("sequencer did not return to idle");

endmodule

// ----- rtl/mecanum_wheel_pi_speed_loop_core.sv -----
`timescale 1ns / 1ps
// Mecanum wheel PI speed loop, top level: sequencer plus datapath.
// Items are taken one at a time: the wheels share one multiplier, five steps each,
// and a new item is accepted only after the last one reaches the output register.
// The output register lets the next item be taken while a result waits.
// Synchronous active-high reset clears gains, error sums and handshake state.
// Depends on mwps_pkg, mwps_if, mwps_ctrl and mwps_datapath.

module mecanum_wheel_pi_speed_loop_core (
   input  logic                               clock,
   input  logic                               reset,
   mwps_req_if.sink                           req_chan,
   mwps_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [mwps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mwps_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mwps_pkg::*;

   cmd_type      cmd;
   stat_type     stat;
   req_item_type req_item;
   rsp_item_type rsp_item;
   logic         req_ready;
   logic         rsp_valid;

   // Gather the request payload
   assign req_item.cmd_x       = req_chan.cmd_x;
   assign req_item.cmd_y       = req_chan.cmd_y;
   assign req_item.cmd_rot     = req_chan.cmd_rot;
   assign req_item.speed_scale = req_chan.speed_scale;
   assign req_item.enc_count0  = req_chan.enc_count0;
   assign req_item.enc_count1  = req_chan.enc_count1;
   assign req_item.enc_count2  = req_chan.enc_count2;
   assign req_item.enc_count3  = req_chan.enc_count3;
   assign req_chan.ready       = req_ready;

   mwps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   mwps_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_item  (rsp_item)
   );

   // Drive the result channel
   assign rsp_chan.valid    = rsp_valid;
   assign rsp_chan.duty0    = rsp_item.duty0;
   assign rsp_chan.forward0 = rsp_item.forward0;
   assign rsp_chan.duty1    = rsp_item.duty1;
   assign rsp_chan.forward1 = rsp_item.forward1;
   assign rsp_chan.duty2    = rsp_item.duty2;
   assign rsp_chan.forward2 = rsp_item.forward2;
   assign rsp_chan.duty3    = rsp_item.duty3;
   assign rsp_chan.forward3 = rsp_item.forward3;

endmodule
